### hdl/efr_pkg.sv
// Shared types, codes and byte constants for the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package efr_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEBUG_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PASS_DEBUG = 2'd1;

  localparam logic [7:0] BYTE_START  = 8'hF0;
  localparam logic [7:0] BYTE_ESCAPE = 8'hF1;
  localparam logic [7:0] BYTE_ACK    = 8'hF2;
  localparam logic [7:0] BYTE_ERR_LO = 8'hF3;
  localparam logic [7:0] BYTE_RESEND = 8'hFF;
  localparam logic [7:0] ESC_MASK    = 8'h80;

  localparam logic [2:0] KIND_BODY   = 3'd0;
  localparam logic [2:0] KIND_ACK    = 3'd1;
  localparam logic [2:0] KIND_ERROR  = 3'd2;
  localparam logic [2:0] KIND_RESEND = 3'd3;
  localparam logic [2:0] KIND_STRAY  = 3'd4;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NACK = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        esc;
    logic [15:0] len;
    logic [15:0] cnt;
    logic        dbg;
  } rx_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        is_last;
    logic        is_debug;
    logic [15:0] body_length;
    logic [1:0]  reply;
  } rx_result_t;

  localparam rx_state_t RX_CLEAR = '{phase: PH_IDLE, esc: 1'b0, len: 16'd0, cnt: 16'd0,
                                      dbg: 1'b0};
  localparam rx_state_t RX_OPEN  = '{phase: PH_LEN_HI, esc: 1'b0, len: 16'd0, cnt: 16'd0,
                                      dbg: 1'b0};

endpackage
`default_nettype wire

### hdl/efr_decode.sv
// Per-byte decode: next receive state and the optional result for one byte.
`timescale 1ns / 1ps
`default_nettype none
module efr_decode (
  input  efr_pkg::rx_state_t  state_i,
  input  logic                cmd_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          debug_code_i,
  input  logic                pass_debug_i,
  output efr_pkg::rx_state_t  state_nxt_o,
  output logic                res_valid_o,
  output efr_pkg::rx_result_t res_o
);

  always_comb begin
    logic [7:0]  b;
    logic [15:0] cnt_inc;
    logic        last;
    logic        dbg_n;
    b           = byte_i;
    cnt_inc     = state_i.cnt + 16'd1;
    last        = 1'b0;
    dbg_n       = state_i.dbg;
    state_nxt_o = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: efr_pkg::KIND_BODY, data_byte: byte_i, is_last: 1'b0,
                    is_debug: 1'b0, body_length: 16'd0, reply: efr_pkg::REPLY_NONE};
    priority if (cmd_i) begin
      state_nxt_o = efr_pkg::RX_CLEAR;
    end else if (state_i.phase == efr_pkg::PH_IDLE) begin
      res_valid_o = 1'b1;
      priority if (byte_i == efr_pkg::BYTE_START) begin
        res_valid_o = 1'b0;
        state_nxt_o = efr_pkg::RX_OPEN;
      end else if (byte_i == efr_pkg::BYTE_ACK) begin
        res_o.kind = efr_pkg::KIND_ACK;
      end else if (byte_i == efr_pkg::BYTE_RESEND) begin
        res_o.kind = efr_pkg::KIND_RESEND;
      end else if (byte_i >= efr_pkg::BYTE_ERR_LO) begin
        res_o.kind = efr_pkg::KIND_ERROR;
      end else begin
        res_o.kind  = efr_pkg::KIND_STRAY;
        res_o.reply = efr_pkg::REPLY_NACK;
      end
    end else if (byte_i == efr_pkg::BYTE_START) begin
      state_nxt_o = efr_pkg::RX_OPEN;
    end else if (state_i.phase == efr_pkg::PH_BODY && state_i.len == 16'd0) begin
      state_nxt_o = state_i;
    end else if (!state_i.esc && byte_i == efr_pkg::BYTE_ESCAPE) begin
      state_nxt_o.esc = 1'b1;
    end else begin
      if (state_i.esc) begin
        b = byte_i | efr_pkg::ESC_MASK;
      end
      state_nxt_o.esc = 1'b0;
      unique case (state_i.phase)
        efr_pkg::PH_LEN_HI: begin
          state_nxt_o.len   = {b, 8'd0};
          state_nxt_o.phase = efr_pkg::PH_LEN_LO;
        end
        efr_pkg::PH_LEN_LO: begin
          state_nxt_o.len   = {state_i.len[15:8], state_i.len[7:0] | b};
          state_nxt_o.cnt   = 16'd0;
          state_nxt_o.phase = efr_pkg::PH_BODY;
        end
        default: begin
          if (state_i.cnt == 16'd0) begin
            dbg_n = (b == debug_code_i);
          end
          last            = (cnt_inc == state_i.len);
          state_nxt_o.cnt = cnt_inc;
          state_nxt_o.dbg = dbg_n;
          if (last) begin
            state_nxt_o = efr_pkg::RX_CLEAR;
          end
          res_o.is_last     = last;
          res_o.is_debug    = dbg_n;
          res_o.body_length = state_i.len;
          res_o.reply       = last ? efr_pkg::REPLY_ACK : efr_pkg::REPLY_NONE;
          if (dbg_n && !pass_debug_i) begin
            res_valid_o     = last;
            res_o.data_byte = 8'd0;
          end else begin
            res_valid_o     = 1'b1;
            res_o.data_byte = b;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/efr_out_reg.sv
// Result register that holds one transfer until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module efr_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  efr_pkg::rx_result_t res_i,
  output logic                free_o,
  input  logic                out_stall,
  output logic                out_valid,
  output efr_pkg::rx_result_t out_res_o
);

  logic                valid_r;
  logic                valid_nxt;
  efr_pkg::rx_result_t res_r;

  assign free_o    = !valid_r || !out_stall;
  assign valid_nxt = load_i || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign out_res_o = res_r;

endmodule
`default_nettype wire

### hdl/escaped_frame_receiver_core.sv
// Top level of the escaped, length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none
// Takes one received byte per transfer and accepts a new one every clock cycle unless
// in_stall is high. A byte is captured in the input register and decoded against the
// receive state in the next cycle; its result, if any, is loaded into the result register
// when that is free, and it is held there until the consumer takes it. The result
// register is the only buffer on the output side, so a stalled result stalls the input
// only when the input register holds a byte that gives a result.
// Registers (debug frame code, pass debug) are written through the cfg_ port, which
// is always ready; write them only while no byte is in flight.
module escaped_frame_receiver_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_kind,
  output logic [7:0]                    out_data_byte,
  output logic                          out_is_last,
  output logic                          out_is_debug,
  output logic [15:0]                   out_body_length,
  output logic [1:0]                    out_reply,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic                in_valid_r;
  logic                in_cmd_r;
  logic [7:0]          in_byte_r;
  logic [7:0]          debug_code_r;
  logic                pass_debug_r;
  efr_pkg::rx_state_t  state_r;
  efr_pkg::rx_state_t  state_nxt;
  logic                res_valid;
  efr_pkg::rx_result_t res;
  efr_pkg::rx_result_t out_res;
  logic                out_free;
  logic                advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!res_valid || out_free);
  assign in_stall  = in_valid_r && !advance;

  efr_decode u_decode (
    .state_i      (state_r),
    .cmd_i        (in_cmd_r),
    .byte_i       (in_byte_r),
    .debug_code_i (debug_code_r),
    .pass_debug_i (pass_debug_r),
    .state_nxt_o  (state_nxt),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  efr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (advance && res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res_o (out_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      state_r      <= efr_pkg::RX_CLEAR;
      debug_code_r <= 8'd0;
      pass_debug_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == efr_pkg::CFG_DEBUG_CODE) begin
          debug_code_r <= cfg_data;
        end else if (cfg_index == efr_pkg::CFG_PASS_DEBUG) begin
          pass_debug_r <= cfg_data[0];
        end
      end
    end
    if (in_valid && !in_stall) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_rx_byte;
    end
  end

  assign out_kind        = out_res.kind;
  assign out_data_byte   = out_res.data_byte;
  assign out_is_last     = out_res.is_last;
  assign out_is_debug    = out_res.is_debug;
  assign out_body_length = out_res.body_length;
  assign out_reply       = out_res.reply;

endmodule
`default_nettype wire

### hdl/efr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module efr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic        out_is_last,
  input  logic [15:0] out_body_length,
  input  logic [1:0]  out_reply
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) && $stable(out_kind))
    else $error("result changed while stalled");

  a_last_acks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == efr_pkg::KIND_BODY |-> out_is_last == (out_reply == efr_pkg::REPLY_ACK))
    else $error("ACK reply not tied to final body byte");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != efr_pkg::KIND_BODY |-> !out_is_last && out_body_length == 16'd0)
    else $error("status result carries frame fields");

  a_nack_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reply == efr_pkg::REPLY_NACK) == (out_kind == efr_pkg::KIND_STRAY))
    else $error("NACK reply not tied to stray byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind escaped_frame_receiver_core efr_checker u_efr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_data_byte   (out_data_byte),
  .out_is_last     (out_is_last),
  .out_body_length (out_body_length),
  .out_reply       (out_reply)
);
`default_nettype wire

### tb/tb_escaped_frame_receiver_core.sv
// Self-checking testbench for the escaped frame receiver core, predicting every result transfer.
`timescale 1ns / 1ps
module tb_escaped_frame_receiver_core;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned HoldCycles  = 400;

  class deframer_scoreboard;
    logic [7:0]          debug_code;
    logic                pass_debug;
    efr_pkg::rx_state_t  rx;
    efr_pkg::rx_result_t pending_results[$];
    int unsigned         mismatches;

    function new();
      debug_code = 8'h00;
      pass_debug = 1'b0;
      rx = efr_pkg::RX_CLEAR;
      mismatches = 0;
    endfunction

    function void write_reg(logic [efr_pkg::CfgIdxW-1:0] idx, logic [7:0] data);
      case (idx)
        efr_pkg::CFG_DEBUG_CODE: debug_code = data;
        efr_pkg::CFG_PASS_DEBUG: pass_debug = data[0];
        default: ;
      endcase
    endfunction

    function void add_result(logic [2:0] k, logic [7:0] d, logic last, logic dbg,
                             logic [15:0] len, logic [1:0] rep);
      efr_pkg::rx_result_t r;
      r.kind = k;
      r.data_byte = d;
      r.is_last = last;
      r.is_debug = dbg;
      r.body_length = len;
      r.reply = rep;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void note_byte(logic restart, logic [7:0] raw);
      logic [7:0]  b;
      logic        last;
      logic        dbg;
      logic [15:0] len;
      b = raw;
      if (restart) begin
        rx = efr_pkg::RX_CLEAR;
        return;
      end
      if (rx.phase == efr_pkg::PH_IDLE) begin
        if (b == efr_pkg::BYTE_START) rx = efr_pkg::RX_OPEN;
        else if (b == efr_pkg::BYTE_ACK)
          add_result(efr_pkg::KIND_ACK, b, 1'b0, 1'b0, 16'd0, efr_pkg::REPLY_NONE);
        else if (b == efr_pkg::BYTE_RESEND)
          add_result(efr_pkg::KIND_RESEND, b, 1'b0, 1'b0, 16'd0, efr_pkg::REPLY_NONE);
        else if (b >= efr_pkg::BYTE_ERR_LO)
          add_result(efr_pkg::KIND_ERROR, b, 1'b0, 1'b0, 16'd0, efr_pkg::REPLY_NONE);
        else
          add_result(efr_pkg::KIND_STRAY, b, 1'b0, 1'b0, 16'd0, efr_pkg::REPLY_NACK);
        return;
      end
      if (b == efr_pkg::BYTE_START) begin
        rx = efr_pkg::RX_OPEN;
        return;
      end
      // zero length: discard until the next start marker or restart
      if (rx.phase == efr_pkg::PH_BODY && rx.len == 16'd0) return;
      if (rx.esc) begin
        b = b | efr_pkg::ESC_MASK;
        rx.esc = 1'b0;
      end else if (b == efr_pkg::BYTE_ESCAPE) begin
        rx.esc = 1'b1;
        return;
      end
      case (rx.phase)
        efr_pkg::PH_LEN_HI: begin
          rx.len = {b, 8'h00};
          rx.phase = efr_pkg::PH_LEN_LO;
        end
        efr_pkg::PH_LEN_LO: begin
          rx.len[7:0] = b;
          rx.cnt = 16'd0;
          rx.phase = efr_pkg::PH_BODY;
        end
        default: begin
          if (rx.cnt == 16'd0) rx.dbg = (b == debug_code);
          rx.cnt = rx.cnt + 16'd1;
          last = (rx.cnt == rx.len);
          len = rx.len;
          dbg = rx.dbg;
          if (last) rx = efr_pkg::RX_CLEAR;
          if (dbg && !pass_debug) begin
            if (last)
              add_result(efr_pkg::KIND_BODY, 8'h00, 1'b1, 1'b1, len, efr_pkg::REPLY_ACK);
          end else begin
            add_result(efr_pkg::KIND_BODY, b, last, dbg, len,
                       last ? efr_pkg::REPLY_ACK : efr_pkg::REPLY_NONE);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(efr_pkg::rx_result_t got);
      efr_pkg::rx_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d data %0h",
                 $time, got.kind, got.data_byte);
        mismatches++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      compare_field("is_last", 16'(want.is_last), 16'(got.is_last));
      compare_field("is_debug", 16'(want.is_debug), 16'(got.is_debug));
      compare_field("body_length", want.body_length, got.body_length);
      compare_field("reply", 16'(want.reply), 16'(got.reply));
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_cmd;
  logic [7:0]                   in_rx_byte;
  logic                         out_valid;
  logic                         out_stall;
  logic [2:0]                   out_kind;
  logic [7:0]                   out_data_byte;
  logic                         out_is_last;
  logic                         out_is_debug;
  logic [15:0]                  out_body_length;
  logic [1:0]                   out_reply;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [efr_pkg::CfgIdxW-1:0]  cfg_index;
  logic [7:0]                   cfg_data;

  deframer_scoreboard sb;
  int unsigned        sent_items;
  int unsigned        stuck_cycles;
  int unsigned        tx_mode;
  int unsigned        hold_request;
  logic               hold_active;

  escaped_frame_receiver_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_is_last     (out_is_last),
    .out_is_debug    (out_is_debug),
    .out_body_length (out_body_length),
    .out_reply       (out_reply),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : transfer_monitor
    efr_pkg::rx_result_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_byte(in_cmd, in_rx_byte);
      if (out_valid && !out_stall) begin
        seen.kind = out_kind;
        seen.data_byte = out_data_byte;
        seen.is_last = out_is_last;
        seen.is_debug = out_is_debug;
        seen.body_length = out_body_length;
        seen.reply = out_reply;
        sb.check_result(seen);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    int unsigned rx_mode;
    out_stall = 1'b0;
    rx_mode = 1;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request != 0) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
        hold_active = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) rx_mode = $urandom_range(0, 1);
      gap = (rx_mode == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_byte(logic cmd_bit, logic [7:0] b);
    int unsigned gap;
    gap = (hold_active || tx_mode == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd_bit;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send(logic [7:0] b);
    send_byte(1'b0, b);
  endtask

  // sends a value so that the block reads it back unchanged
  task automatic send_value(logic [7:0] v);
    int unsigned how;
    how = $urandom_range(0, 3);
    if (v == efr_pkg::BYTE_START || v == efr_pkg::BYTE_ESCAPE || (v[7] && how == 0)) begin
      send(efr_pkg::BYTE_ESCAPE);
      send(v & ~efr_pkg::ESC_MASK);
    end else if (v[7] && how == 1) begin
      send(efr_pkg::BYTE_ESCAPE);
      send(v);
    end else begin
      send(v);
    end
  endtask

  task automatic send_frame(logic [15:0] len, int unsigned cut);
    int unsigned i;
    logic [7:0]  v;
    send(efr_pkg::BYTE_START);
    send_value(len[15:8]);
    send_value(len[7:0]);
    for (i = 0; i < len && i < cut; i++) begin
      if (i == 0 && $urandom_range(0, 2) == 0) v = sb.debug_code;
      else if ($urandom_range(0, 3) == 0) v = 8'($urandom_range(8'hF0, 8'hFF));
      else v = 8'($urandom);
      send_value(v);
    end
    if (len == 16'd0) begin
      repeat ($urandom_range(1, 3)) send(8'($urandom));
    end else if (cut < len) begin
      if ($urandom_range(0, 1) == 1) send_byte(1'b1, 8'($urandom));
      else send(efr_pkg::BYTE_START);
    end
  endtask

  task automatic set_config(logic [7:0] code, logic pass);
    cfg_valid <= 1'b1;
    cfg_index <= efr_pkg::CFG_DEBUG_CODE;
    cfg_data <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= efr_pkg::CFG_PASS_DEBUG;
    cfg_data <= {7'd0, pass};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned r;
    int unsigned target;
    logic [15:0] len;
    logic [7:0]  code;
    logic        pass;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = efr_pkg::CFG_DEBUG_CODE;
    cfg_data = 8'h00;
    sent_items = 0;
    stuck_cycles = 0;
    tx_mode = 1;
    hold_request = 0;
    hold_active = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // status bytes outside a frame
    send(8'h00); send(efr_pkg::BYTE_ESCAPE); send(efr_pkg::BYTE_ACK);
    send(efr_pkg::BYTE_ERR_LO); send(8'hFE); send(efr_pkg::BYTE_RESEND); send(8'h7F);
    // debug frame at reset settings: data suppressed, final byte reported as zero
    send(efr_pkg::BYTE_START); send(8'h00); send(8'h02); send(8'h00); send(8'hAA);
    // start marker during a pending escape, zero length, then a restart
    send(efr_pkg::BYTE_START); send(efr_pkg::BYTE_ESCAPE); send(efr_pkg::BYTE_START);
    send(8'h00); send(8'h00);
    send(8'h55); send_byte(1'b1, 8'hFF); send(efr_pkg::BYTE_ESCAPE);
    // escaped and plain high bytes in the body
    send(efr_pkg::BYTE_START); send(8'h00); send(8'h03); send(8'h10);
    send(efr_pkg::BYTE_ESCAPE); send(8'h7F); send(8'hF5);
    wait_idle();

    for (p = 0; p < NumPhases; p++) begin
      if (p < 4) begin
        code = p[0] ? 8'hFF : 8'h00;
        pass = (p == 1 || p == 2);
      end else begin
        code = 8'($urandom);
        pass = 1'($urandom);
      end
      set_config(code, pass);
      if (p == 1) hold_request = HoldCycles;
      target = sent_items + RandomItems / NumPhases;
      while (sent_items < target) begin
        tx_mode = $urandom_range(0, 2);
        r = $urandom_range(0, 99);
        if (r < 62) begin
          r = $urandom_range(0, 39);
          if (r < 2) len = 16'd0;
          else if (r < 32) len = 16'($urandom_range(1, 8));
          else if (r < 39) len = 16'($urandom_range(9, 40));
          else len = 16'($urandom_range(120, 300));
          send_frame(len, 32'hFFFF_FFFF);
        end else if (r < 74) begin
          send_frame(16'($urandom), $urandom_range(0, 6));
        end else if (r < 92) begin
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1) == 1) send(8'($urandom_range(8'hF2, 8'hFF)));
            else send(8'($urandom));
          end
        end else begin
          send_byte(1'($urandom), 8'($urandom));
        end
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
